// File: design/b7s_pkg.sv
// shared types, constants and segment table of the seven-segment formatter
`timescale 1ns / 1ps
`default_nettype none

package b7s_pkg;

  // field widths
  localparam int ValueW    = 16;
  localparam int NumDigits = 5;
  localparam int BcdW      = 4 * NumDigits;
  localparam int NumCells  = ValueW;
  localparam int SegCount  = 8;
  localparam int SegW      = 8;
  localparam int PointW    = 3;

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic RegPointPosition = 1'b0;

  // segment codes, bit0 = a .. bit6 = g, bit7 = point
  localparam logic [SegW-1:0] CodeMinus = 8'h40;
  localparam logic [SegW-1:0] CodeBlank = 8'h00;
  localparam logic [SegW-1:0] CodePoint = 8'h80;

  // one word in flight along the conversion chain
  typedef struct packed {
    logic              valid;
    logic              negative;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } cell_t;

  // decimal digit to segment pattern
  function automatic logic [SegW-1:0] seg_of(input logic [3:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = CodeBlank;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: design/b7s_in_if.sv
// input channel: value and sign with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface b7s_in_if import b7s_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              negative;

  modport source (output valid, output value, output negative, input ready);
  modport sink (input valid, input value, input negative, output ready);
endinterface

`default_nettype wire

// File: design/b7s_out_if.sv
// result channel: eight segment codes with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface b7s_out_if import b7s_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SegW-1:0] digit_0;
  logic [SegW-1:0] digit_1;
  logic [SegW-1:0] digit_2;
  logic [SegW-1:0] digit_3;
  logic [SegW-1:0] digit_4;
  logic [SegW-1:0] digit_5;
  logic [SegW-1:0] digit_6;
  logic [SegW-1:0] digit_7;

  modport source (output valid, output digit_0, output digit_1, output digit_2,
                  output digit_3, output digit_4, output digit_5, output digit_6,
                  output digit_7, input ready);
  modport sink (input valid, input digit_0, input digit_1, input digit_2,
                input digit_3, input digit_4, input digit_5, input digit_6,
                input digit_7, output ready);
endinterface

`default_nettype wire

// File: design/b7s_cell.sv
// one double-dabble step: add-3 correction, then shift one binary bit into bcd
`timescale 1ns / 1ps
`default_nettype none

module b7s_cell import b7s_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  wire cell_t cell_in,
  output cell_t      cell_out
);

  logic              valid_r;
  logic              valid_nxt;
  logic              negative_r;
  logic [BcdW-1:0]   bcd_r;
  logic [BcdW-1:0]   bcd_nxt;
  logic [ValueW-1:0] bin_r;
  logic [ValueW-1:0] bin_nxt;
  logic [BcdW-1:0]   adj;

  // correct each digit of five or more, then shift in the next msb
  always_comb begin
    adj = cell_in.bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    bcd_nxt   = {adj[BcdW-2:0], cell_in.bin[ValueW-1]};
    bin_nxt   = {cell_in.bin[ValueW-2:0], 1'b0};
    valid_nxt = cell_in.valid;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      negative_r <= cell_in.negative;
      bcd_r      <= bcd_nxt;
      bin_r      <= bin_nxt;
    end
  end

  assign cell_out = '{valid: valid_r, negative: negative_r, bcd: bcd_r, bin: bin_r};

endmodule

`default_nettype wire

// File: design/b7s_format.sv
// maps bcd digits to segment codes with point, zero blanking and minus sign
`timescale 1ns / 1ps
`default_nettype none

module b7s_format import b7s_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire cell_t             cell_in,
  input  wire logic [PointW-1:0] point,
  output logic                   valid,
  output logic [SegW-1:0]        digit [SegCount]
);

  logic                valid_r;
  logic [SegW-1:0]     digit_r   [SegCount];
  logic [SegW-1:0]     digit_nxt [SegCount];
  logic [3:0]          dig       [SegCount];
  logic [SegCount-1:0] has_pt;
  logic [SegCount-1:0] keep;

  always_comb begin
    // digits above the bcd width are always zero
    for (int i = 0; i < SegCount; i++) begin
      dig[i]    = 4'd0;
      has_pt[i] = (point != '0) && (point == PointW'(i));
    end
    for (int i = 0; i < NumDigits; i++) begin
      dig[i] = cell_in.bcd[4*i +: 4];
    end

    // a position is kept if it or anything above it is not a plain zero
    keep[SegCount-1] = (dig[SegCount-1] != 4'd0) || has_pt[SegCount-1];
    for (int i = SegCount - 2; i >= 1; i--) begin
      keep[i] = keep[i+1] || (dig[i] != 4'd0) || has_pt[i];
    end
    keep[0] = 1'b1;

    // position 0 always shows its digit
    digit_nxt[0] = seg_of(dig[0]) | (has_pt[0] ? CodePoint : CodeBlank);

    // shown digits, then minus just above the highest shown one
    for (int i = 1; i < SegCount; i++) begin
      if (keep[i]) begin
        digit_nxt[i] = seg_of(dig[i]) | (has_pt[i] ? CodePoint : CodeBlank);
      end else if (cell_in.negative && keep[i-1]) begin
        digit_nxt[i] = CodeMinus;
      end else begin
        digit_nxt[i] = CodeBlank;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cell_in.valid;
    end
  end

  // output codes
  always_ff @(posedge clk) begin
    if (adv) begin
      digit_r <= digit_nxt;
    end
  end

  assign valid = valid_r;
  assign digit = digit_r;

endmodule

`default_nettype wire

// File: design/binary_to_seven_segment_formatter.sv
// Binary to seven-segment formatter, top level.
//
// in_chan takes a 16-bit unsigned value and a sign flag; out_chan returns the
// segment codes of eight display positions, position 0 rightmost, bit 7 the
// decimal point. The cfg_ APB port holds point_position at byte address 0
// (0 = no point); writes with paddr bit 2 set are ignored and read back zero.
//
// A word runs through a chain of 16 double-dabble cells, one binary bit per
// cell, then one formatting register: 17 registers in all. A new word is taken
// every cycle while no result is stalled at the output, so the throughput is
// one word per cycle, set by the one-step-per-cell chain.
// The whole chain moves as one: when a result waits on out_chan and the
// receiver holds ready low, the chain and in_chan.ready stall until it is
// taken, and nothing is lost. Reset clears all valid flags, empties the chain
// and sets point_position to 0. point_position is read at the formatting
// stage, so change it only while no word is in the chain.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_seven_segment_formatter import b7s_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  b7s_in_if.sink                   in_chan,
  b7s_out_if.source                out_chan,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic      [CfgDataW-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  logic              adv;
  logic [PointW-1:0] point_r;
  cell_t             chain [NumCells+1];
  logic              out_valid;
  logic [SegW-1:0]   digit [SegCount];
  logic [SegCount-1:0] minus_vec;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CfgAddrW-1] == RegPointPosition) begin
      point_r <= cfg_pwdata[PointW-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CfgAddrW-1] == RegPointPosition) ?
                      CfgDataW'(point_r) : '0;

  // whole chain advances unless a result is stuck at the output
  assign adv           = !out_valid || out_chan.ready;
  assign in_chan.ready = adv;

  // word entering the chain
  assign chain[0] = '{valid: in_chan.valid, negative: in_chan.negative,
                      bcd: '0, bin: in_chan.value};

  // conversion cells
  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    b7s_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (chain[c]),
      .cell_out (chain[c+1])
    );
  end

  // formatting and output register
  b7s_format u_format (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cell_in (chain[NumCells]),
    .point   (point_r),
    .valid   (out_valid),
    .digit   (digit)
  );

  assign out_chan.valid   = out_valid;
  assign out_chan.digit_0 = digit[0];
  assign out_chan.digit_1 = digit[1];
  assign out_chan.digit_2 = digit[2];
  assign out_chan.digit_3 = digit[3];
  assign out_chan.digit_4 = digit[4];
  assign out_chan.digit_5 = digit[5];
  assign out_chan.digit_6 = digit[6];
  assign out_chan.digit_7 = digit[7];

  // positions holding a minus sign
  always_comb begin
    for (int i = 0; i < SegCount; i++) begin
      minus_vec[i] = (digit[i] == CodeMinus);
    end
  end

  // a stalled result also stalls the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while output stalled");

  // the rightmost position always shows a digit
  a_pos0_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (digit[0] != CodeBlank && digit[0] != CodeMinus))
    else $error("position 0 blank or minus");

  // at most one minus sign, never at position 0
  a_one_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($onehot0(minus_vec) && !minus_vec[0]))
    else $error("bad minus placement");

  // a result leaves the chain only after a valid word went through the last cell
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |-> $past(chain[NumCells].valid))
    else $error("result without word");

endmodule

`default_nettype wire

// File: tb/binary_to_seven_segment_formatter_test.sv
// self-checking bench of the seven-segment formatter: directed and random words, point setting over apb
`timescale 1ns / 1ps

module binary_to_seven_segment_formatter_test;
  import b7s_pkg::*;

  localparam int NumPhases  = 10;
  localparam int PhaseWords = 143;
  localparam int Latency    = 17;
  localparam int StallLimit = 2000;
  localparam logic [CfgAddrW-1:0] PointAddr = {RegPointPosition, 2'b00};

  // segment pattern of each decimal digit, index 0 at the right
  localparam logic [9:0][SegW-1:0] DigitSeg = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  // point position of the first eight random phases, extremes first
  localparam logic [7:0][PointW-1:0] PointPlan = {
    3'd4, 3'd2, 3'd6, 3'd3, 3'd1, 3'd5, 3'd7, 3'd0
  };

  typedef logic [SegCount-1:0][SegW-1:0] seg_row_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              negative;
  } word_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  b7s_in_if  in_ch ();
  b7s_out_if out_ch ();

  word_t       pending_words[$];
  seg_row_t    expected_codes[$];
  logic [PointW-1:0] point_reg = '0;
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  logic        in_taken = 1'b0;
  logic        calm = 1'b0;

  binary_to_seven_segment_formatter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_ch),
    .out_chan   (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // display codes for one value, sign and point setting
  function automatic seg_row_t format_display(input logic [ValueW-1:0] value,
                                              input logic negative,
                                              input logic [PointW-1:0] point);
    seg_row_t    codes;
    int unsigned rest;
    int unsigned top;
    int          i;
    logic        shown;
    rest  = value;
    top   = 0;
    shown = 1'b0;
    for (i = 0; i < SegCount; i++) begin
      codes[i] = DigitSeg[rest % 10];
      rest     = rest / 10;
      if (point != 0 && point == i) begin
        codes[i] = codes[i] | CodePoint;
      end
    end
    // blank leading plain zeros, a pointed zero stops the blanking
    for (i = SegCount - 1; i > 0; i--) begin
      if (!shown) begin
        if (codes[i] == DigitSeg[0]) begin
          codes[i] = CodeBlank;
        end else begin
          top   = i;
          shown = 1'b1;
        end
      end
    end
    // minus just above the highest shown digit, dropped if no room
    if (negative && top + 1 < SegCount) begin
      codes[top + 1] = CodeMinus;
    end
    return codes;
  endfunction

  // random magnitude, weighted toward digit-count boundaries and short numbers
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned span;
    case ($urandom_range(9))
      0: begin
        span = 10 ** $urandom_range(4);
        return ValueW'(span - $urandom_range(1));
      end
      1: return $urandom_range(1) ? '1 : '0;
      2, 3, 4: begin
        span = 10 ** $urandom_range(1, 5) - 1;
        if (span > 65535) begin
          span = 65535;
        end
        return ValueW'($urandom_range(span));
      end
      default: return ValueW'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < 100) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic queue_word(input logic [ValueW-1:0] value, input logic negative);
    word_t w;
    w.value    = value;
    w.negative = negative;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // apb write of the point register, setup then access
  task automatic set_point(input logic [PointW-1:0] point);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PointAddr;
    cfg_pwdata  <= CfgDataW'(point);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    point_reg = point;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // wait until every queued word is taken and every result checked
  task automatic drain();
    do @(negedge clk); while (words_taken != words_queued || expected_codes.size() != 0);
  endtask

  // input driver
  always @(negedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        w = pending_words.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.value    <= w.value;
        in_ch.negative <= w.negative;
      end else begin
        in_ch.valid    <= 1'b0;
        in_ch.value    <= ValueW'($urandom);
        in_ch.negative <= 1'($urandom_range(1));
      end
    end
  end

  // result receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 6);
  end

  // accepted words, predict their display codes
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      expected_codes.push_back(format_display(in_ch.value, in_ch.negative, point_reg));
      words_taken <= words_taken + 1;
    end
    in_taken <= in_ch.valid && in_ch.ready;
  end

  // result monitor, field by field against the oldest prediction
  always @(posedge clk) begin
    seg_row_t got;
    seg_row_t want;
    int       d;
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.digit_7, out_ch.digit_6, out_ch.digit_5, out_ch.digit_4,
             out_ch.digit_3, out_ch.digit_2, out_ch.digit_1, out_ch.digit_0};
      if (expected_codes.size() == 0) begin
        note_mismatch($sformatf("unexpected word %h", got));
      end else begin
        want = expected_codes.pop_front();
        for (d = 0; d < SegCount; d++) begin
          if (got[d] !== want[d]) begin
            note_mismatch($sformatf("digit_%0d got %h want %h (point %0d)",
                                    d, got[d], want[d], point_reg));
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("timeout after %0d idle cycles", StallLimit);
      $display("FAIL binary_to_seven_segment_formatter");
      $finish;
    end
  end

  // stimulus
  initial begin
    int ph;
    int n;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.negative = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    rst_n          = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no point: zero, extremes, digit-count boundaries, minus with value zero
    set_point(3'd0);
    queue_word(16'd0, 1'b0);
    queue_word(16'd0, 1'b1);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'hFFFF, 1'b1);
    queue_word(16'd1, 1'b1);
    queue_word(16'd9, 1'b0);
    queue_word(16'd10, 1'b1);
    queue_word(16'd99, 1'b0);
    queue_word(16'd100, 1'b1);
    queue_word(16'd9999, 1'b1);
    queue_word(16'd10000, 1'b0);
    queue_word(16'd12345, 1'b1);
    queue_word(16'hAAAA, 1'b0);
    queue_word(16'h5555, 1'b1);
    drain();

    // point at the top: minus has no room
    set_point(3'd7);
    queue_word(16'd0, 1'b1);
    queue_word(16'hFFFF, 1'b1);
    queue_word(16'd7, 1'b0);
    drain();

    // pointed high zero keeps the zeros below it
    set_point(3'd5);
    queue_word(16'd42, 1'b1);
    queue_word(16'd0, 1'b0);
    drain();

    set_point(3'd1);
    queue_word(16'd0, 1'b1);
    queue_word(16'd5, 1'b0);
    drain();

    // random phases, one of them without any idling
    for (ph = 0; ph < NumPhases; ph++) begin
      set_point(ph < 8 ? PointPlan[ph] : PointW'($urandom_range(7)));
      calm = (ph == 3);
      for (n = 0; n < PhaseWords; n++) begin
        queue_word(pick_value(), 1'($urandom_range(1)));
      end
      drain();
    end
    calm = 1'b0;

    repeat (2 * Latency) @(posedge clk);
    if (expected_codes.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", expected_codes.size()));
    end
    if (mismatches == 0) begin
      $display("PASS binary_to_seven_segment_formatter");
    end else begin
      $display("FAIL binary_to_seven_segment_formatter");
    end
    $finish;
  end

endmodule
